// ===== src/subword_bit_packer_core_defines.svh =====
// Assertion macros shared by the packer modules.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef SUBWORD_BIT_PACKER_CORE_DEFINES_SVH
`define SUBWORD_BIT_PACKER_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define SBP_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SBP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sbp_pkg.sv =====
package sbp_pkg;

   localparam int DATA_W      = 64;
   localparam int FILL_W      = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register indexes on the csr port
   localparam logic [1:0] CSR_ELEMENT_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_WORD_SIZE_CODE = 2'd1;
   localparam logic [1:0] CSR_BIG_ENDIAN     = 2'd2;

   localparam logic [6:0] ELEMENT_WIDTH_RESET = 7'd4;

   typedef struct packed {
      logic [DATA_W-1:0] data_value;
      logic              last;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_word;
      logic              final_res;
   } rsp_payload_type;

   typedef struct packed {
      logic [6:0] element_width;
      logic [1:0] word_size_code;
      logic       big_endian;
   } cfg_type;

   // Queue write strobes from the front end
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   function automatic logic [DATA_W-1:0] low_mask(input logic [FILL_W-1:0] bits);
      logic [DATA_W-1:0] m;
      if (bits >= FILL_W'(DATA_W)) begin
         m = '1;
      end else begin
         m = (DATA_W'(1) << bits) - DATA_W'(1);
      end
      return m;
   endfunction

   function automatic logic [FILL_W-1:0] word_bits(input logic [1:0] code,
                                                   input int max_bits);
      logic [FILL_W-1:0] wb;
      wb = FILL_W'(8) << code;
      if (int'(wb) > max_bits) begin
         wb = FILL_W'(max_bits);
      end
      return wb;
   endfunction

endpackage

// ===== src/sbp_front.sv =====
`include "subword_bit_packer_core_defines.svh"

module sbp_front #(
   parameter int MAX_WORD_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sbp_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sbp_pkg::req_payload_type   req_payload,
   input  logic                       q_space,
   output sbp_pkg::push_type          push,
   output logic [MAX_WORD_BITS:0]     entry0,
   output logic [MAX_WORD_BITS:0]     entry1
);

   localparam int FW = sbp_pkg::FILL_W;

   logic [MAX_WORD_BITS-1:0] accum_ff, accum_in;
   logic [FW-1:0]            fill_ff, fill_in;

   logic                     accept;
   logic [FW-1:0]            ew;
   logic [FW-1:0]            wb;
   logic                     flush_prev;
   logic [FW-1:0]            base_fill;
   logic [MAX_WORD_BITS-1:0] base_acc;
   logic [sbp_pkg::DATA_W-1:0] shifted;
   logic [sbp_pkg::DATA_W-1:0] full_mask;
   logic [MAX_WORD_BITS-1:0] word_mask;
   logic [MAX_WORD_BITS-1:0] new_acc;
   logic [FW:0]              base_sum;
   logic [FW-1:0]            new_fill;

   assign req_ready = q_space;
   assign accept    = req_valid && q_space;

   always_comb begin
      // clamp element width to 1..64
      if (cfg.element_width == '0) begin
         ew = FW'(1);
      end else if (cfg.element_width > FW'(64)) begin
         ew = FW'(64);
      end else begin
         ew = cfg.element_width;
      end
      wb = sbp_pkg::word_bits(cfg.word_size_code, MAX_WORD_BITS);

      flush_prev = (fill_ff != '0) &&
                   (({1'b0, fill_ff} + {1'b0, ew}) > {1'b0, wb});
      base_fill  = flush_prev ? '0 : fill_ff;
      base_acc   = (flush_prev || fill_ff == '0) ? '0 : accum_ff;

      shifted   = (req_payload.data_value & sbp_pkg::low_mask(ew)) << base_fill[5:0];
      full_mask = sbp_pkg::low_mask(wb);
      word_mask = full_mask[MAX_WORD_BITS-1:0];
      new_acc   = (base_acc | shifted[MAX_WORD_BITS-1:0]) & word_mask;

      base_sum  = {1'b0, base_fill} + {1'b0, ew};
      new_fill  = (base_sum > {1'b0, wb}) ? wb : base_sum[FW-1:0];
   end

   always_comb begin
      push.first  = accept && (flush_prev || req_payload.last);
      push.second = accept && flush_prev && req_payload.last;
      entry0      = flush_prev ? {1'b0, accum_ff} : {1'b1, new_acc};
      entry1      = {1'b1, new_acc};
   end

   always_comb begin
      accum_in = accum_ff;
      fill_in  = fill_ff;
      if (accept) begin
         accum_in = new_acc;
         fill_in  = req_payload.last ? '0 : new_fill;
      end
   end

   always_ff @(posedge clock) begin
      accum_ff <= accum_in;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   `SBP_ASSERT_NEXT(a_last_clears_fill, accept && req_payload.last, fill_ff == '0, "fill kept")
   `SBP_ASSERT_HOLDS(a_fill_bounded, fill_ff <= FW'(MAX_WORD_BITS), "fill exceeds word size")

endmodule

// ===== src/sbp_queue.sv =====
`include "subword_bit_packer_core_defines.svh"

module sbp_queue #(
   parameter int ENTRY_W = 65
) (
   input  logic               clock,
   input  logic               reset,
   input  sbp_pkg::push_type  push,
   input  logic [ENTRY_W-1:0] wr0,
   input  logic [ENTRY_W-1:0] wr1,
   input  logic               pop,
   output logic               space,
   output logic               not_empty,
   output logic [ENTRY_W-1:0] head
);

   localparam int PW = sbp_pkg::QUEUE_PTR_W;
   localparam int CW = sbp_pkg::QUEUE_CNT_W;

   logic [ENTRY_W-1:0] slots_ff [sbp_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      n_push;

   assign n_push    = CW'(push.first) + CW'(push.second);
   assign space     = count_ff <= CW'(sbp_pkg::QUEUE_DEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[PW-1:0];
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + n_push - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         slots_ff[wr_ptr_ff] <= wr0;
      end
      if (push.second) begin
         slots_ff[wr_ptr_ff + PW'(1)] <= wr1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SBP_ASSERT_HOLDS(a_no_overflow, count_ff <= CW'(sbp_pkg::QUEUE_DEPTH), "queue overflow")
   `SBP_ASSERT_IMPL(a_no_underflow, pop, count_ff != '0, "pop from empty queue")
   `SBP_ASSERT_IMPL(a_push_room, push.first, space, "push without two free slots")

endmodule

// ===== src/sbp_back.sv =====
module sbp_back #(
   parameter int MAX_WORD_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sbp_pkg::cfg_type         cfg,
   input  logic                     q_not_empty,
   input  logic [MAX_WORD_BITS:0]   q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sbp_pkg::rsp_payload_type rsp_payload
);

   localparam int DW = sbp_pkg::DATA_W;
   localparam int FW = sbp_pkg::FILL_W;

   logic                     rsp_valid_ff, rsp_valid_in;
   sbp_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [FW-1:0] wb;
   logic [3:0]    nb;
   logic [DW-1:0] word;
   logic [DW-1:0] swapped;
   logic [3:0]    sel;

   always_comb begin
      wb      = sbp_pkg::word_bits(cfg.word_size_code, MAX_WORD_BITS);
      nb      = wb[6:3];
      word    = DW'(q_head[MAX_WORD_BITS-1:0]) & sbp_pkg::low_mask(wb);
      swapped = '0;
      sel     = '0;
      for (int i = 0; i < DW / 8; i++) begin
         sel = nb - 4'(i) - 4'd1;
         if (4'(i) < nb) begin
            swapped[8*i +: 8] = word[{sel[2:0], 3'b000} +: 8];
         end
      end
   end

   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (q_pop) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.out_word  = cfg.big_endian ? swapped : word;
         rsp_payload_in.final_res = q_head[MAX_WORD_BITS];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/subword_bit_packer_core.sv =====
// Subword bit packer: packs elements LSB first into 8/16/32/64-bit words.
// req_* : one element per transaction (data_value masked to element_width,
//         last marks the end of a stream and flushes the partial word).
// rsp_* : packed words, first byte in bits 7:0 unless big_endian, final_res on the
//         last word. One transaction may yield zero, one or two words.
// csr_* : register writes (0 element_width, 1 word_size_code, 2 big_endian),
//         always ready; write only while no transaction is in flight.
// Throughput: one element per cycle while req_ready is high; the packer
//   does one shift-or per cycle and the queue drains one word per cycle
//   unless rsp_ready holds it; a closing, stream-ending element yields two words.
// Path: a word is written to the queue at the edge accepting its transaction,
//   then loaded into the output register once that register is free.
// Stall: a four-entry queue sits between packer and output register;
//   req_ready drops while fewer than two entries are free, so a stalled
//   receiver backs up the input without losing words.
// Reset: registers return to width 4, 8-bit words, little endian; the
//   partial word and the queue are discarded.
module subword_bit_packer_core #(
   parameter int MAX_WORD_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sbp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sbp_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [6:0]               csr_wdata
);

   sbp_pkg::cfg_type         cfg_ff, cfg_in;
   sbp_pkg::push_type        push;
   logic [MAX_WORD_BITS:0]   entry0, entry1;
   logic [MAX_WORD_BITS:0]   q_head;
   logic                     q_space;
   logic                     q_not_empty;
   logic                     q_pop;

   // Registers accept a write every cycle
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sbp_pkg::CSR_ELEMENT_WIDTH:  cfg_in.element_width  = csr_wdata;
            sbp_pkg::CSR_WORD_SIZE_CODE: cfg_in.word_size_code = csr_wdata[1:0];
            sbp_pkg::CSR_BIG_ENDIAN:     cfg_in.big_endian     = csr_wdata[0];
            default:                     cfg_in = cfg_ff; // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.element_width  <= sbp_pkg::ELEMENT_WIDTH_RESET;
         cfg_ff.word_size_code <= '0;
         cfg_ff.big_endian     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify the element, pack it, queue the words it closes
   sbp_front #(
      .MAX_WORD_BITS(MAX_WORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_space     (q_space),
      .push        (push),
      .entry0      (entry0),
      .entry1      (entry1)
   );

   // Queue: hold finished words so either side can stall on its own
   sbp_queue #(
      .ENTRY_W(MAX_WORD_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr0       (entry0),
      .wr1       (entry1),
      .pop       (q_pop),
      .space     (q_space),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // Back: trim to word size, apply byte order, register the result
   sbp_back #(
      .MAX_WORD_BITS(MAX_WORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
